### rtl/pcss_pkg.sv
// ----------------------------------------------------------------------------
// pcss_pkg: shared types and constants of the sample scheduler
// Operation codes of the shared arithmetic unit, configuration register
// indexes, fixed field widths and the structs passed between modules.
// ----------------------------------------------------------------------------
package pcss_pkg;

   // fixed field widths
   localparam int TIME_W       = 32;
   localparam int ID_W         = 8;
   localparam int PERIOD_W     = 16;
   localparam int IDX_W        = 2;
   localparam int CFG_CHANNELS = 4;
   localparam int ENABLE_W     = CFG_CHANNELS;
   localparam int IDS_W        = CFG_CHANNELS * ID_W;
   localparam int PERIODS_W    = CFG_CHANNELS * PERIOD_W;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = PERIODS_W;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_FIELD_W  = IDX_W + ID_W + TIME_W;
   localparam int RSP_DATA_W   = 48;

   // register reset values
   localparam logic [ENABLE_W-1:0] RESET_ENABLE = ENABLE_W'(1);
   localparam logic [IDS_W-1:0]    RESET_IDS    = IDS_W'(24);

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ENABLE  = 2'd0,
      REG_IDS     = 2'd1,
      REG_PERIODS = 2'd2
   } reg_index_type;

   // shared unit operations
   typedef enum logic [1:0] {
      ALU_INC,
      ALU_ADD,
      ALU_LE
   } alu_op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      alu_op_type        op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              le;
   } alu_rsp_type;

   typedef struct packed {
      logic [ENABLE_W-1:0]  enable;
      logic [IDS_W-1:0]     ids;
      logic [PERIODS_W-1:0] periods;
   } cfg_type;

   typedef struct packed {
      logic              busy;
      logic [TIME_W-1:0] now;
   } stat_type;

endpackage

### rtl/periodic_channel_sample_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_channel_sample_scheduler: periodic multi-channel sample scheduler
// Keeps a time counter and per-channel due times and issues one sample
// request per due channel on each tick.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries load and tick transactions: req_tuser set loads the time
//   counter from req_tdata, req_tuser clear is one tick. A tick while the
//   time counter is zero does nothing.
//   rsp_* carries sample requests in channel order, rsp_tlast on the final
//   one of a tick. A tick with no due channel gives no transaction.
//   csr_* writes configuration: 0 enable mask, 1 packed ids, 2 packed
//   periods. Write only while the block is idle.
// Timing
//   Loads and unsynchronized ticks leave the block idle. A synchronized
//   tick keeps req_tready low until its walk ends: the shared adder
//   runs the due test for each channel and the due-time update for each
//   due channel, then the requests move one by one to the output
//   register. A stalled receiver holds the drain; the final request can
//   wait in the output register while the next transaction is accepted.
//   Reset clears time, due times and the output valid flag at once.
// ----------------------------------------------------------------------------
module periodic_channel_sample_scheduler #(
   parameter int CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: time_value[31:0]
   input  logic [pcss_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: kind[0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: channel_index[1:0], channel_id[9:2], sample_time[41:10], zeros
   output logic [pcss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [pcss_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pcss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pcss_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;
   stat_type             stat;
   logic [IDX_W-1:0]     rsp_index;
   logic [ID_W-1:0]      rsp_id;
   logic [TIME_W-1:0]    rsp_time;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_ENABLE:  cfg_in.enable  = csr_wdata[ENABLE_W-1:0];
            REG_IDS:     cfg_in.ids     = csr_wdata[IDS_W-1:0];
            REG_PERIODS: cfg_in.periods = csr_wdata[PERIODS_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable  <= RESET_ENABLE;
         cfg_ff.ids     <= RESET_IDS;
         cfg_ff.periods <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // shared arithmetic unit
   pcss_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // walk sequencer
   pcss_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_time  (req_tdata[TIME_W-1:0]),
      .req_ready (req_tready),
      .alu_req   (alu_req),
      .alu_rsp   (alu_rsp),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (rsp_index),
      .rsp_id    (rsp_id),
      .rsp_time  (rsp_time),
      .rsp_last  (rsp_tlast),
      .stat      (stat)
   );

   // result packing
   assign rsp_tdata = {(RSP_DATA_W - RSP_FIELD_W)'(0), rsp_time, rsp_id, rsp_index};

   // a synchronized tick starts a walk that blocks the input
   a_tick_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser && stat.now != '0) |=> !req_tready)
      else $error("input ready right after a synchronized tick");

   // a load transaction sets the time counter
   a_load_time : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=>
         (stat.now == $past(req_tdata[TIME_W-1:0])))
      else $error("time counter not loaded");

   // reset leaves the block idle with no pending result
   a_reset_idle : assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready && !stat.busy))
      else $error("block not idle after reset");

endmodule

### rtl/pcss_alu.sv
// ----------------------------------------------------------------------------
// pcss_alu: shared 32-bit add and compare unit
// One carry-chain adder serves the time increment, the due-time update
// (time plus period) and the due test (due time <= time).
// ----------------------------------------------------------------------------
module pcss_alu (
   input  pcss_pkg::alu_req_type req,
   output pcss_pkg::alu_rsp_type rsp
);
   import pcss_pkg::*;

   logic [TIME_W-1:0] x;
   logic [TIME_W-1:0] y;
   logic              cin;
   logic [TIME_W:0]   s;

   // operand steering: a <= b is tested as b - a without borrow
   always_comb begin
      x   = req.a;
      y   = '0;
      cin = 1'b0;
      case (req.op)
         ALU_INC: begin
            x   = req.a;
            y   = '0;
            cin = 1'b1;
         end
         ALU_ADD: begin
            x   = req.a;
            y   = req.b;
            cin = 1'b0;
         end
         ALU_LE: begin
            x   = req.b;
            y   = ~req.a;
            cin = 1'b1;
         end
         default: begin
            x   = req.a;
            y   = '0;
            cin = 1'b0;
         end
      endcase
   end

   // single adder
   assign s       = {1'b0, x} + {1'b0, y} + (TIME_W + 1)'(cin);
   assign rsp.sum = s[TIME_W-1:0];
   assign rsp.le  = s[TIME_W];

endmodule

### rtl/pcss_ctrl.sv
// ----------------------------------------------------------------------------
// pcss_ctrl: channel walk sequencer
// Holds the time counter and the due times, walks the channels one at a
// time through the shared unit, then drains the due channels in index
// order into the output register.
// ----------------------------------------------------------------------------
module pcss_ctrl #(
   parameter int CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcss_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   input  logic                          req_kind,
   input  logic [pcss_pkg::TIME_W-1:0]   req_time,
   output logic                          req_ready,
   output pcss_pkg::alu_req_type         alu_req,
   input  pcss_pkg::alu_rsp_type         alu_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pcss_pkg::IDX_W-1:0]    rsp_index,
   output logic [pcss_pkg::ID_W-1:0]     rsp_id,
   output logic [pcss_pkg::TIME_W-1:0]   rsp_time,
   output logic                          rsp_last,
   output pcss_pkg::stat_type            stat
);
   import pcss_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

   state_type            state_ff, state_in;
   logic [CH_W-1:0]      idx_ff, idx_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [CHANNELS-1:0]  due_mask_ff, due_mask_in;
   logic [TIME_W-1:0]    next_due_ff [CHANNELS];
   logic                 nd_we;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic                 rsp_last_ff;
   logic                 rsp_load;

   logic                 accept;
   logic                 synced;
   logic [IDX_W-1:0]     sel;
   logic                 enabled;
   logic                 is_due;
   logic [TIME_W-1:0]    period_ext;
   logic                 slot_free;
   logic [CH_W-1:0]      pick_idx;
   logic                 pick_found;
   logic [IDX_W-1:0]     pick_sel;
   logic [CHANNELS-1:0]  pick_oh;
   logic [CHANNELS-1:0]  rest;
   logic                 pick_last;

   // channel lookup for the walk position
   assign accept     = req_valid && req_ready;
   assign synced     = (time_ff != '0);
   assign sel        = IDX_W'(idx_ff);
   assign enabled    = (int'(idx_ff) < CFG_CHANNELS) && cfg.enable[sel];
   assign is_due     = enabled && alu_rsp.le;
   assign period_ext = TIME_W'(cfg.periods[PERIOD_W*sel +: PERIOD_W]);
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // lowest pending due channel
   always_comb begin
      pick_idx   = '0;
      pick_found = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (due_mask_ff[i] && !pick_found) begin
            pick_idx   = CH_W'(i);
            pick_found = 1'b1;
         end
      end
   end

   assign pick_oh   = due_mask_ff & ~(due_mask_ff - CHANNELS'(1));
   assign rest      = due_mask_ff & ~pick_oh;
   assign pick_last = (rest == '0);
   assign pick_sel  = IDX_W'(pick_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_kind && synced) state_in = ST_CMP;
         end
         ST_CMP: begin
            if (is_due)                  state_in = ST_ADD;
            else if (idx_ff == LAST_IDX) state_in = ST_EMIT;
         end
         ST_ADD: begin
            if (idx_ff == LAST_IDX) state_in = ST_EMIT;
            else                    state_in = ST_CMP;
         end
         ST_EMIT: begin
            if (due_mask_ff == '0)           state_in = ST_IDLE;
            else if (slot_free && pick_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready   = 1'b0;
      alu_req.op  = ALU_INC;
      alu_req.a   = time_ff;
      alu_req.b   = '0;
      time_in     = time_ff;
      idx_in      = idx_ff;
      due_mask_in = due_mask_ff;
      nd_we       = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_in    = '0;
            if (accept) begin
               if (req_kind)    time_in = req_time;
               else if (synced) time_in = alu_rsp.sum;
            end
         end
         ST_CMP: begin
            alu_req.op = ALU_LE;
            alu_req.a  = next_due_ff[idx_ff];
            alu_req.b  = time_ff;
            if (is_due) begin
               due_mask_in[idx_ff] = 1'b1;
            end else if (idx_ff != LAST_IDX) begin
               idx_in = idx_ff + CH_W'(1);
            end
         end
         ST_ADD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = time_ff;
            alu_req.b  = period_ext;
            nd_we      = 1'b1;
            idx_in     = idx_ff + CH_W'(1);
         end
         ST_EMIT: begin
            if (due_mask_ff != '0 && slot_free) begin
               rsp_load    = 1'b1;
               due_mask_in = rest;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // control state, time counter and due times
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         time_ff      <= '0;
         due_mask_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) next_due_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         time_ff      <= time_in;
         due_mask_ff  <= due_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (nd_we) next_due_ff[idx_ff] <= alu_rsp.sum;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= pick_sel;
         rsp_id_ff    <= cfg.ids[ID_W*pick_sel +: ID_W];
         rsp_time_ff  <= time_ff;
         rsp_last_ff  <= pick_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_id    = rsp_id_ff;
   assign rsp_time  = rsp_time_ff;
   assign rsp_last  = rsp_last_ff;
   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.now  = time_ff;

endmodule

### tb/sample_request_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_request_checker: scoreboard of the periodic sample scheduler
// Follows the configuration writes, predicts the sample requests of every
// accepted tick and compares them in order with the result channel.
// ----------------------------------------------------------------------------
module sample_request_checker #(
   parameter int CHANNELS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pcss_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [pcss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [pcss_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [pcss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatches,
   output int                                outstanding
);
   import pcss_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  chan;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] stamp;
      logic              last;
   } sample_req_type;

   // mirrored configuration
   logic [ENABLE_W-1:0]  enable_mask;
   logic [IDS_W-1:0]     id_table;
   logic [PERIODS_W-1:0] period_table;

   // predicted scheduler state
   logic [TIME_W-1:0] time_now;
   logic [TIME_W-1:0] due_at [CHANNELS];

   sample_req_type expected_samples [$];

   function automatic void report_field(string field, logic [TIME_W-1:0] want_v,
                                        logic [TIME_W-1:0] got_v);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
               want_v, got_v);
      mismatches++;
   endfunction

   // one tick: unless time is zero, advance time, then walk the channels in index order
   function automatic void predict_tick();
      sample_req_type burst [$];
      sample_req_type item;
      logic [TIME_W-1:0] now;
      if (time_now == '0) begin
         return;
      end
      time_now = time_now + 1'b1;
      now = time_now;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         if (ch < CFG_CHANNELS && enable_mask[ch % CFG_CHANNELS]
             && due_at[ch] <= now) begin
            item.chan  = IDX_W'(ch);
            item.id    = id_table[ID_W * (ch % CFG_CHANNELS) +: ID_W];
            item.stamp = now;
            item.last  = 1'b0;
            burst.push_back(item);
            due_at[ch] = now + TIME_W'(period_table[PERIOD_W * (ch % CFG_CHANNELS)
                                                    +: PERIOD_W]);
         end
      end
      for (int k = 0; k < burst.size(); k++) begin
         item = burst[k];
         item.last = (k == burst.size() - 1);
         expected_samples.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      sample_req_type want;
      sample_req_type got;
      if (reset) begin
         enable_mask  = RESET_ENABLE;
         id_table     = RESET_IDS;
         period_table = '0;
         time_now     = '0;
         mismatches   = 0;
         foreach (due_at[c]) due_at[c] = '0;
         expected_samples.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               REG_ENABLE:  enable_mask  = csr_wdata[ENABLE_W-1:0];
               REG_IDS:     id_table     = csr_wdata[IDS_W-1:0];
               REG_PERIODS: period_table = csr_wdata[PERIODS_W-1:0];
               default: ;
            endcase
         end

         // result transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.chan  = rsp_tdata[IDX_W-1:0];
            got.id    = rsp_tdata[IDX_W +: ID_W];
            got.stamp = rsp_tdata[IDX_W + ID_W +: TIME_W];
            got.last  = rsp_tlast;
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample request, expected none, actual %p",
                        $time, got);
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (got.chan !== want.chan) begin
                  report_field("channel_index", TIME_W'(want.chan), TIME_W'(got.chan));
               end
               if (got.id !== want.id) begin
                  report_field("channel_id", TIME_W'(want.id), TIME_W'(got.id));
               end
               if (got.stamp !== want.stamp) begin
                  report_field("sample_time", want.stamp, got.stamp);
               end
               if (got.last !== want.last) begin
                  report_field("last", TIME_W'(want.last), TIME_W'(got.last));
               end
            end
         end

         // input transaction: tuser set loads the time counter
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               time_now = req_tdata[TIME_W-1:0];
            end else begin
               predict_tick();
            end
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the periodic sample scheduler
// Directed load and tick sequences cover sync, wrap and period corners,
// then randomized phases change the configuration and the idling of both
// channels while a scoreboard checks every sample request.
// ----------------------------------------------------------------------------
module testbench;
   import pcss_pkg::*;

   localparam int CHANNELS        = 4;
   localparam int CYCLE_LIMIT     = 200000;
   // settle time covers a tick walk with every channel due
   localparam int SETTLE_CYCLES   = 3 * CHANNELS + 8;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 24;
   localparam logic KIND_TICK     = 1'b0;
   localparam logic KIND_LOAD     = 1'b1;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = KIND_TICK;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   int          mismatches;
   int          outstanding;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   always #4 clock = ~clock;

   periodic_channel_sample_scheduler #(
      .CHANNELS(CHANNELS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   sample_request_checker #(
      .CHANNELS(CHANNELS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** periodic_channel_sample_scheduler: FAILED **");
         $finish;
      end
   end

   // one input transaction, with random idle cycles ahead of it
   task automatic send_item(input logic kind, input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      // ready is stable between the falling edge and the accepting edge
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // drain all predicted requests, then let the sequencer finish its walk
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] period_word;
      logic [31:0]           load_time;
      int                    roll;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: only channel 0, id 24, period zero
      send_item(KIND_TICK, 32'd0);            // not synchronized yet
      send_item(KIND_LOAD, 32'd5);
      send_item(KIND_TICK, 32'd0);
      send_item(KIND_TICK, $urandom);         // period zero fires again

      wait_quiet();
      write_reg(REG_ENABLE, 64'hF);
      write_reg(REG_IDS, 64'hFFA5_5A00);
      write_reg(REG_PERIODS, {16'd3, 16'hFFFF, 16'd1, 16'd0});
      send_item(KIND_TICK, 32'd0);            // every channel due
      send_item(KIND_TICK, 32'd0);

      // time wrap: channel 1 lands on due time zero
      send_item(KIND_LOAD, 32'hFFFF_FFFD);
      send_item(KIND_TICK, 32'd0);
      send_item(KIND_TICK, 32'd0);
      send_item(KIND_TICK, 32'd0);
      send_item(KIND_TICK, 32'd0);            // counter is zero again

      // loading zero desynchronizes
      send_item(KIND_LOAD, 32'd0);
      send_item(KIND_TICK, 32'hFFFF_FFFF);
      send_item(KIND_LOAD, 32'hFFFF_FFFF);
      send_item(KIND_TICK, 32'd0);
      // moving time backwards leaves later due times pending
      send_item(KIND_LOAD, 32'd3);
      send_item(KIND_TICK, 32'hFFFF_FFFF);
      send_item(KIND_TICK, 32'd0);

      // randomized phases
      for (int p = 0; p < PHASES; p++) begin
         wait_quiet();
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase

         if (p == 4) begin
            write_reg(REG_ENABLE, 64'h0);
         end else if (p == 1 || p == 6) begin
            write_reg(REG_ENABLE, 64'hF);
         end else begin
            write_reg(REG_ENABLE, 64'($urandom_range(15)));
         end

         if (p == 0) begin
            write_reg(REG_IDS, 64'h0);
         end else if (p == 1) begin
            write_reg(REG_IDS, 64'hFFFF_FFFF);
         end else begin
            write_reg(REG_IDS, 64'($urandom));
         end

         // mostly short periods so requests stay frequent
         if (p == 0) begin
            period_word = '0;
         end else if (p == 1) begin
            period_word = '1;
         end else begin
            for (int c = 0; c < CFG_CHANNELS; c++) begin
               period_word[16 * c +: 16] = ($urandom_range(3) == 0) ?
                                           16'($urandom_range(65535)) :
                                           16'($urandom_range(6));
            end
         end
         write_reg(REG_PERIODS, period_word);

         send_item(KIND_LOAD, 32'($urandom_range(1, 1000)));
         repeat (ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
               case ($urandom_range(9))
                  0:       load_time = 32'd0;
                  1, 2:    load_time = $urandom;
                  3, 4:    load_time = 32'hFFFF_FFF0 | 32'($urandom_range(15));
                  default: load_time = 32'($urandom_range(1, 5000));
               endcase
               send_item(KIND_LOAD, load_time);
            end else begin
               send_item(KIND_TICK, $urandom);
            end
         end
      end

      wait_quiet();
      if (mismatches == 0 && outstanding == 0) begin
         $display("** periodic_channel_sample_scheduler: PASSED **");
      end else begin
         $display("** periodic_channel_sample_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
